/* design/fcsg_pkg.sv */
// Shared constants and types for the filled circle span generator.
package fcsg_pkg;
	localparam int RADIUS_BITS_DEF = 10;
	localparam int COORD_BITS_DEF  = 12;
	localparam int OUT_BITS        = 13;
	localparam int BOUND_NUM       = 1414;
	localparam int BOUND_DEN       = 1000;
	localparam int ADDR_BITS       = 4;

	localparam logic [1:0] REG_CENTER_X = 2'd0;
	localparam logic [1:0] REG_CENTER_Y = 2'd1;
	localparam logic [1:0] REG_RADIUS   = 2'd2;

	typedef struct packed {
		logic valid;
		logic oob;
	} fcsg_tag_t;
endpackage

/* design/fcsg_row_if.sv */
// Row index input channel.
interface fcsg_row_if
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
);
	logic                   valid;
	logic                   ready;
	logic [RADIUS_BITS-1:0] row_index;

	modport source (output valid, output row_index, input ready);
	modport sink (input valid, input row_index, output ready);
endinterface

/* design/fcsg_span_if.sv */
// Fill span output channel.
interface fcsg_span_if
	import fcsg_pkg::*;
;
	logic                       valid;
	logic                       ready;
	logic signed [OUT_BITS-1:0] span_y;
	logic signed [OUT_BITS-1:0] span_x_left;
	logic signed [OUT_BITS-1:0] span_x_right;
	logic                       row_valid;
	logic                       last_of_row;

	modport source (output valid, output span_y, output span_x_left, output span_x_right,
		output row_valid, output last_of_row, input ready);
	modport sink (input valid, input span_y, input span_x_left, input span_x_right,
		input row_valid, input last_of_row, output ready);
endinterface

/* design/filled_circle_span_generator.sv */
// Filled circle span generator top level: config registers, root cell chain, span output.
//
// Each accepted row index i yields four fill spans (y = k+j, k+i, k-i, k-j) with
// j = floor(sqrt(r*r - i*i)), or a single word with row_valid low when i*1414 > r*1000.
// Rows enter a registered prep stage and then a chain of RADIUS_BITS square root cells,
// one root bit per cell, and the output stage registers each finished row. The single
// output channel sends one word per cycle while span_out.ready is high, so a row inside
// the bound is held for four words before the next row loads (one word for rows past the
// bound); the chain holds further rows while the output stage drains. Write center_x,
// center_y and radius only while idle.
module filled_circle_span_generator
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 psel,
	input  logic                 penable,
	input  logic                 pwrite,
	input  logic [ADDR_BITS-1:0] paddr,
	input  logic [31:0]          pwdata,
	output logic [31:0]          prdata,
	output logic                 pready,
	fcsg_row_if.sink             row_in,
	fcsg_span_if.source          span_out
);
	localparam int NW = 2 * RADIUS_BITS;
	localparam int RW = RADIUS_BITS + 1;
	localparam int BW = RADIUS_BITS + 11;

	logic signed [COORD_BITS-1:0] center_x_q;
	logic signed [COORD_BITS-1:0] center_y_q;
	logic [RADIUS_BITS-1:0]       radius_q;
	logic                         wr_en;

	assign pready = 1'b1;
	assign wr_en  = psel && penable && pwrite;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			center_x_q <= '0;
			center_y_q <= '0;
			radius_q   <= '0;
		end else if (wr_en) begin
			case (paddr[3:2])
				REG_CENTER_X: center_x_q <= pwdata[COORD_BITS-1:0];
				REG_CENTER_Y: center_y_q <= pwdata[COORD_BITS-1:0];
				REG_RADIUS:   radius_q   <= pwdata[RADIUS_BITS-1:0];
				default: begin
				end
			endcase
		end
	end

	always_comb begin
		case (paddr[3:2])
			REG_CENTER_X: prdata = 32'(center_x_q);
			REG_CENTER_Y: prdata = 32'(center_y_q);
			REG_RADIUS:   prdata = 32'(radius_q);
			default:      prdata = '0;
		endcase
	end

	logic                   adv;
	logic [NW-1:0]          sq_i;
	logic [NW-1:0]          sq_r;
	logic [BW-1:0]          lhs;
	logic [BW-1:0]          rhs;
	fcsg_tag_t              tag_in;

	fcsg_tag_t              tag_s1;
	logic [NW-1:0]          n_s1;
	logic [RADIUS_BITS-1:0] idx_s1;

	always_comb begin
		sq_i         = NW'(row_in.row_index) * NW'(row_in.row_index);
		sq_r         = NW'(radius_q) * NW'(radius_q);
		lhs          = BW'(row_in.row_index) * BW'(BOUND_NUM);
		rhs          = BW'(radius_q) * BW'(BOUND_DEN);
		tag_in.valid = row_in.valid;
		tag_in.oob   = (lhs > rhs);
	end

	assign row_in.ready = adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_s1 <= '0;
		end else if (adv) begin
			tag_s1 <= tag_in;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_s1   <= sq_r - sq_i;
			idx_s1 <= row_in.row_index;
		end
	end

	fcsg_tag_t              tag_c  [RADIUS_BITS+1];
	logic [NW-1:0]          n_c    [RADIUS_BITS+1];
	logic [RW-1:0]          rem_c  [RADIUS_BITS+1];
	logic [RADIUS_BITS-1:0] root_c [RADIUS_BITS+1];
	logic [RADIUS_BITS-1:0] idx_c  [RADIUS_BITS+1];

	assign tag_c[0]  = tag_s1;
	assign n_c[0]    = n_s1;
	assign rem_c[0]  = '0;
	assign root_c[0] = '0;
	assign idx_c[0]  = idx_s1;

	for (genvar c = 0; c < RADIUS_BITS; c++) begin : g_cell
		fcsg_cell #(
			.RADIUS_BITS(RADIUS_BITS)
		) u_cell (
			.clk    (clk),
			.arst_n (arst_n),
			.adv    (adv),
			.tag_i  (tag_c[c]),
			.n_i    (n_c[c]),
			.rem_i  (rem_c[c]),
			.root_i (root_c[c]),
			.idx_i  (idx_c[c]),
			.tag_o  (tag_c[c+1]),
			.n_o    (n_c[c+1]),
			.rem_o  (rem_c[c+1]),
			.root_o (root_c[c+1]),
			.idx_o  (idx_c[c+1])
		);
	end

	fcsg_emit #(
		.RADIUS_BITS(RADIUS_BITS),
		.COORD_BITS (COORD_BITS)
	) u_emit (
		.clk      (clk),
		.arst_n   (arst_n),
		.center_x (center_x_q),
		.center_y (center_y_q),
		.tag_i    (tag_c[RADIUS_BITS]),
		.idx_i    (idx_c[RADIUS_BITS]),
		.root_i   (root_c[RADIUS_BITS]),
		.load     (adv),
		.span_out (span_out)
	);
endmodule

/* design/fcsg_cell.sv */
// One square root cell: resolves one root bit and hands the row to the next cell.
module fcsg_cell
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF
) (
	input  logic                     clk,
	input  logic                     arst_n,
	input  logic                     adv,
	input  fcsg_tag_t                tag_i,
	input  logic [2*RADIUS_BITS-1:0] n_i,
	input  logic [RADIUS_BITS:0]     rem_i,
	input  logic [RADIUS_BITS-1:0]   root_i,
	input  logic [RADIUS_BITS-1:0]   idx_i,
	output fcsg_tag_t                tag_o,
	output logic [2*RADIUS_BITS-1:0] n_o,
	output logic [RADIUS_BITS:0]     rem_o,
	output logic [RADIUS_BITS-1:0]   root_o,
	output logic [RADIUS_BITS-1:0]   idx_o
);
	localparam int NW = 2 * RADIUS_BITS;
	localparam int RW = RADIUS_BITS + 1;

	logic [RW+1:0] rem_sh;
	logic [RW+1:0] trial;
	logic [RW+1:0] diff;
	logic          ge;

	fcsg_tag_t              tag_q;
	logic [NW-1:0]          n_q;
	logic [RW-1:0]          rem_q;
	logic [RADIUS_BITS-1:0] root_q;
	logic [RADIUS_BITS-1:0] idx_q;

	always_comb begin
		rem_sh = {rem_i, n_i[NW-1:NW-2]};
		trial  = {1'b0, root_i, 2'b01};
		diff   = rem_sh - trial;
		ge     = (rem_sh >= trial);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q <= '0;
		end else if (adv) begin
			tag_q <= tag_i;
		end
	end

	always_ff @(posedge clk) begin
		if (adv) begin
			n_q    <= {n_i[NW-3:0], 2'b00};
			rem_q  <= ge ? diff[RW-1:0] : rem_sh[RW-1:0];
			root_q <= {root_i[RADIUS_BITS-2:0], ge};
			idx_q  <= idx_i;
		end
	end

	assign tag_o  = tag_q;
	assign n_o    = n_q;
	assign rem_o  = rem_q;
	assign root_o = root_q;
	assign idx_o  = idx_q;
endmodule

/* design/fcsg_emit.sv */
// Output stage: holds a row; sends 4 spans (1 if oob), one word per ready cycle.
module fcsg_emit
	import fcsg_pkg::*;
#(
	parameter int RADIUS_BITS = RADIUS_BITS_DEF,
	parameter int COORD_BITS  = COORD_BITS_DEF
) (
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic signed [COORD_BITS-1:0] center_x,
	input  logic signed [COORD_BITS-1:0] center_y,
	input  fcsg_tag_t                    tag_i,
	input  logic [RADIUS_BITS-1:0]       idx_i,
	input  logic [RADIUS_BITS-1:0]       root_i,
	output logic                         load,
	fcsg_span_if.source                  span_out
);
	localparam int SW = ((COORD_BITS > RADIUS_BITS) ? COORD_BITS : RADIUS_BITS) + 2;
	localparam int EW = (SW > OUT_BITS) ? SW : OUT_BITS;

	localparam logic [1:0] PH_TOP_J    = 2'd0;
	localparam logic [1:0] PH_TOP_I    = 2'd1;
	localparam logic [1:0] PH_BOTTOM_I = 2'd2;
	localparam logic [1:0] PH_BOTTOM_J = 2'd3;

	fcsg_tag_t              tag_q;
	logic [1:0]             phase_q;
	logic [RADIUS_BITS-1:0] idx_q;
	logic [RADIUS_BITS-1:0] root_q;

	logic signed [EW-1:0] h;
	logic signed [EW-1:0] k;
	logic signed [EW-1:0] si;
	logic signed [EW-1:0] sj;
	logic signed [EW-1:0] y;
	logic signed [EW-1:0] dx;
	logic                 last;
	logic                 fire;

	always_comb begin
		h  = EW'(center_x);
		k  = EW'(center_y);
		si = EW'($signed({1'b0, idx_q}));
		sj = EW'($signed({1'b0, root_q}));
		case (phase_q)
			PH_TOP_J: begin
				y  = k + sj;
				dx = si;
			end
			PH_TOP_I: begin
				y  = k + si;
				dx = sj;
			end
			PH_BOTTOM_I: begin
				y  = k - si;
				dx = sj;
			end
			PH_BOTTOM_J: begin
				y  = k - sj;
				dx = si;
			end
			default: begin
				y  = '0;
				dx = '0;
			end
		endcase
	end

	assign last = tag_q.oob || (phase_q == PH_BOTTOM_J);
	assign fire = tag_q.valid && span_out.ready;
	assign load = !tag_q.valid || (fire && last);

	assign span_out.valid        = tag_q.valid;
	assign span_out.row_valid    = !tag_q.oob;
	assign span_out.last_of_row  = last;
	assign span_out.span_y       = tag_q.oob ? '0 : y[OUT_BITS-1:0];
	assign span_out.span_x_left  = tag_q.oob ? '0 : OUT_BITS'(h - dx);
	assign span_out.span_x_right = tag_q.oob ? '0 : OUT_BITS'(h + dx);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tag_q   <= '0;
			phase_q <= PH_TOP_J;
		end else if (load) begin
			tag_q   <= tag_i;
			phase_q <= PH_TOP_J;
		end else if (fire) begin
			phase_q <= phase_q + 2'd1;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			idx_q  <= idx_i;
			root_q <= root_i;
		end
	end
endmodule
